/* rtl/core/chllp_pkg.sv */
// ----------------------------------------------------------------------------
// chllp_pkg: shared constants for the catch-handler list length parser
// LEB128 field widths, byte layout and saturation limits.
// ----------------------------------------------------------------------------
package chllp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned PAIR_CNT_W = WORD_W + 1;
  localparam int unsigned LEB_IDX_W = 3;

  // Index of the fifth LEB128 byte, which always ends the value.
  localparam logic [LEB_IDX_W-1:0] LEB_LAST_IDX = 3'd4;

  localparam logic [6:0]        LEB_PAYLOAD_MASK = 7'h7f;
  localparam logic [WORD_W-1:0] WORD_MAX         = 32'hffff_ffff;

endpackage : chllp_pkg

/* rtl/core/catch_handler_list_length_parser.sv */
// ----------------------------------------------------------------------------
// catch_handler_list_length_parser: encoded catch-handler list length parser
// Walks an encoded catch-handler list one byte per beat and reports its size.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one raw list byte in in_tdata and a start flag in
//   in_tuser. A beat with the start flag set opens a new list, dropping any
//   list still in progress without a result. Beats without the flag while
//   no list is open are taken and ignored.
//   The block decodes the unsigned LEB128 list count, then for each handler a
//   signed LEB128 size, skips |size| type/address pairs and, for a size of
//   zero or less, one catch-all address. On the byte that ends the list one
//   result beat leaves on out_tdata: the list length in bytes (saturating)
//   and the decoded handler count.
//   Throughput: one byte per cycle while in_tready is high. All decoding for a
//   byte is done combinationally between the parse state and output registers.
//   Result: registered on the final byte's beat, valid in the cycle after it.
//   Stall: the single output register holds a waiting result; in_tready drops
//   only while that register is full and out_tready is low.
//   Reset (rst_n low, synchronous): parse state returns to idle, the output
//   register empties.
// ----------------------------------------------------------------------------
module catch_handler_list_length_parser (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] begin_req
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [31:0] list_bytes, [63:32] handler_count
);

  typedef enum logic [1:0] {
    PH_COUNT,
    PH_SIZE,
    PH_PAIRS,
    PH_CATCH
  } phase_t;

  localparam int unsigned WW = chllp_pkg::WORD_W;
  localparam int unsigned PW = chllp_pkg::PAIR_CNT_W;
  localparam int unsigned IW = chllp_pkg::LEB_IDX_W;

  // parse state
  logic          busy_r,        busy_nxt;
  phase_t        phase_r,       phase_nxt;
  logic [IW-1:0] leb_idx_r,     leb_idx_nxt;
  logic [WW-1:0] leb_acc_r,     leb_acc_nxt;
  logic [WW-1:0] hnd_left_r,    hnd_left_nxt;
  logic [PW-1:0] pair_left_r,   pair_left_nxt;
  logic          catch_all_r,   catch_all_nxt;
  logic [WW-1:0] byte_total_r,  byte_total_nxt;
  logic [WW-1:0] list_count_r,  list_count_nxt;

  // output register
  logic          out_valid_r;
  logic [WW-1:0] out_bytes_r;
  logic [WW-1:0] out_count_r;

  logic          in_fire;
  logic          list_end;
  logic [WW-1:0] payload;
  logic [WW-1:0] leb_value;
  logic [WW-1:0] size_sx;
  logic [WW-1:0] size_mag;
  logic [WW-1:0] hnd_dec;
  logic [PW-1:0] pair_dec;
  logic          leb_more;

  // Accept while the output register is free or being drained this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    busy_nxt       = busy_r;
    phase_nxt      = phase_r;
    leb_idx_nxt    = leb_idx_r;
    leb_acc_nxt    = leb_acc_r;
    hnd_left_nxt   = hnd_left_r;
    pair_left_nxt  = pair_left_r;
    catch_all_nxt  = catch_all_r;
    byte_total_nxt = byte_total_r;
    list_count_nxt = list_count_r;
    list_end       = 1'b0;
    payload        = '0;
    leb_value      = '0;
    size_sx        = '0;
    size_mag       = '0;
    hnd_dec        = '0;
    pair_dec       = '0;
    leb_more       = 1'b0;

    // Start flag: drop any list in progress and start from a clean slate.
    if (in_tuser) begin
      busy_nxt       = 1'b1;
      phase_nxt      = PH_COUNT;
      leb_idx_nxt    = '0;
      leb_acc_nxt    = '0;
      hnd_left_nxt   = '0;
      pair_left_nxt  = '0;
      catch_all_nxt  = 1'b0;
      byte_total_nxt = '0;
      list_count_nxt = '0;
    end

    if (in_fire && busy_nxt) begin
      if (byte_total_nxt != chllp_pkg::WORD_MAX) begin
        byte_total_nxt = byte_total_nxt + WW'(1);
      end

      // Place the 7 payload bits; the fifth byte lands at bit 28 and its
      // upper bits fall off the word.
      unique case (leb_idx_nxt)
        3'd0:    payload = {25'b0, in_tdata[6:0] & chllp_pkg::LEB_PAYLOAD_MASK};
        3'd1:    payload = {18'b0, in_tdata[6:0], 7'b0};
        3'd2:    payload = {11'b0, in_tdata[6:0], 14'b0};
        3'd3:    payload = {4'b0, in_tdata[6:0], 21'b0};
        default: payload = {in_tdata[3:0], 28'b0};
      endcase
      leb_value = leb_acc_nxt | payload;
      leb_more  = in_tdata[7] && (leb_idx_nxt < chllp_pkg::LEB_LAST_IDX);

      if (leb_more) begin
        leb_acc_nxt = leb_value;
        leb_idx_nxt = leb_idx_nxt + IW'(1);
      end else begin
        leb_acc_nxt = '0;
        leb_idx_nxt = '0;

        // Sign-extend a short signed value from its top payload bit.
        size_sx = leb_value;
        case (leb_idx_r & {IW{!in_tuser}})
          3'd0:    if (leb_value[6])  size_sx = leb_value | 32'hffff_ff80;
          3'd1:    if (leb_value[13]) size_sx = leb_value | 32'hffff_c000;
          3'd2:    if (leb_value[20]) size_sx = leb_value | 32'hffe0_0000;
          3'd3:    if (leb_value[27]) size_sx = leb_value | 32'hf000_0000;
          default: size_sx = leb_value;
        endcase
        size_mag = (size_sx[WW-1] || size_sx == '0) ? (WW'(0) - size_sx) : size_sx;

        hnd_dec  = (hnd_left_nxt != '0) ? hnd_left_nxt - WW'(1) : hnd_left_nxt;
        pair_dec = (pair_left_nxt != '0) ? pair_left_nxt - PW'(1) : pair_left_nxt;

        unique case (phase_nxt)
          PH_COUNT: begin
            list_count_nxt = leb_value;
            hnd_left_nxt   = leb_value;
            if (leb_value == '0) list_end = 1'b1;
            else                 phase_nxt = PH_SIZE;
          end
          PH_SIZE: begin
            catch_all_nxt = size_sx[WW-1] || size_sx == '0;
            pair_left_nxt = {size_mag, 1'b0};
            if (size_mag != '0) begin
              phase_nxt = PH_PAIRS;
            end else if (size_sx[WW-1] || size_sx == '0) begin
              phase_nxt = PH_CATCH;
            end else begin
              hnd_left_nxt = hnd_dec;
              if (hnd_dec == '0) list_end = 1'b1;
              else               phase_nxt = PH_SIZE;
            end
          end
          PH_PAIRS: begin
            pair_left_nxt = pair_dec;
            if (pair_dec == '0) begin
              if (catch_all_nxt) begin
                phase_nxt = PH_CATCH;
              end else begin
                hnd_left_nxt = hnd_dec;
                if (hnd_dec == '0) list_end = 1'b1;
                else               phase_nxt = PH_SIZE;
              end
            end
          end
          default: begin
            catch_all_nxt = 1'b0;
            hnd_left_nxt  = hnd_dec;
            if (hnd_dec == '0) list_end = 1'b1;
            else               phase_nxt = PH_SIZE;
          end
        endcase

        if (list_end) begin
          busy_nxt  = 1'b0;
          phase_nxt = PH_COUNT;
        end
      end
    end

    // Without an accepted beat nothing advances.
    if (!in_fire) begin
      busy_nxt       = busy_r;
      phase_nxt      = phase_r;
      leb_idx_nxt    = leb_idx_r;
      leb_acc_nxt    = leb_acc_r;
      hnd_left_nxt   = hnd_left_r;
      pair_left_nxt  = pair_left_r;
      catch_all_nxt  = catch_all_r;
      byte_total_nxt = byte_total_r;
      list_count_nxt = list_count_r;
      list_end       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      phase_r      <= PH_COUNT;
      leb_idx_r    <= '0;
      leb_acc_r    <= '0;
      hnd_left_r   <= '0;
      pair_left_r  <= '0;
      catch_all_r  <= 1'b0;
      byte_total_r <= '0;
      list_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      phase_r      <= phase_nxt;
      leb_idx_r    <= leb_idx_nxt;
      leb_acc_r    <= leb_acc_nxt;
      hnd_left_r   <= hnd_left_nxt;
      pair_left_r  <= pair_left_nxt;
      catch_all_r  <= catch_all_nxt;
      byte_total_r <= byte_total_nxt;
      list_count_r <= list_count_nxt;
      // Load a finished result, else drop the held one once taken.
      if (list_end) begin
        out_valid_r <= 1'b1;
        out_bytes_r <= byte_total_nxt;
        out_count_r <= list_count_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_bytes_r};

  // A list that ends produces a result on the next cycle.
  a_end_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    list_end |=> out_valid_r)
    else $error("finished list did not reach the output register");

  // Idle parser sits at the count field with an empty LEB128 decoder.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (phase_r == PH_COUNT && leb_idx_r == '0))
    else $error("idle parser holds stale decode state");

  // The LEB128 byte index never runs past the fifth byte.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    leb_idx_r <= chllp_pkg::LEB_LAST_IDX)
    else $error("LEB128 byte index out of range");

  // Pair phase is only entered with values left to skip.
  a_pairs_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAIRS |-> pair_left_r != '0)
    else $error("pair phase with no pair values left");

  // Every reported list consumed at least one byte.
  a_bytes_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_bytes_r != '0)
    else $error("result reports an empty byte count");

endmodule : catch_handler_list_length_parser
